// ----- design/bitvector_rank_select_assert.svh -----
// Assertion macros shared by the checker of the rank/select block.
`ifndef BITVECTOR_RANK_SELECT_ASSERT_SVH
`define BITVECTOR_RANK_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/brs_pkg.sv -----
// ----------------------------------------------------------------------------
// brs_pkg
// Types, constants and helpers shared by the rank/select block.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int MAX_BITS    = 65536;
    localparam int WORD_BITS   = 64;
    localparam int BLOCK_BITS  = 64;
    localparam int SB_BITS     = 512;
    localparam int STORE_WORDS = MAX_BITS / WORD_BITS;
    localparam int SB_DEPTH    = MAX_BITS / SB_BITS;
    localparam int BLK_DEPTH   = MAX_BITS / BLOCK_BITS;
    localparam int BLK_PER_SB  = SB_BITS / BLOCK_BITS;

    localparam int IDX_W  = 17;
    localparam int POS_W  = 16;
    localparam int WA_W   = 10;
    localparam int SBA_W  = 7;
    localparam int BLK_W  = 10;
    localparam int CNT_W  = 17;
    localparam int PC_W   = 7;
    localparam int BI_W   = 11;
    localparam int LR_W   = 18;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_GET    = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_RANK   = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;

    typedef struct packed {
        logic [2:0]       operation;
        logic [IDX_W-1:0] index;
        logic             bit_value;
    } item_t;

    typedef struct packed {
        logic             bit_out;
        logic [CNT_W-1:0] count_out;
        logic [POS_W-1:0] position;
        logic             not_found;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH,
        S_SET_RD, S_SET_WR, S_GET_RD, S_GET_OUT,
        S_BLD_INIT, S_BLD_CHK, S_BLD_RD, S_BLD_PC, S_BLD_UPD,
        S_RK_RD, S_RK_PC, S_RK_SUM, S_RK_OUT,
        S_SEL_INIT, S_SEL_CHK, S_SEL_CMP, S_BACK_CHK, S_BACK_CMP
    } state_t;

    typedef enum logic [1:0] {RET_RANK, RET_SEARCH, RET_BACK} rk_ret_t;

    typedef enum logic [2:0] {
        RES_NONE, RES_GET, RES_RANK, RES_POS, RES_MISS, RES_ZERO
    } res_kind_t;

    typedef struct packed {
        logic      clr_wr;
        logic      latch;
        logic      set_wr;
        logic      rk_addr;
        logic      bld_addr;
        logic      bld_init;
        logic      bld_pc;
        logic      bld_upd;
        logic      rank_init;
        logic      rk_pc;
        logic      rk_sum;
        logic      sel_init;
        logic      sel_mid;
        logic      sel_left;
        logic      sel_right;
        logic      back_pos;
        logic      back_dec;
        res_kind_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       clr_done;
        logic       bld_done;
        logic       want_zero;
        logic       left_gt_right;
        logic       rank_eq_want;
        logic       rank_gt_want;
        logic       rank_eq_want_m1;
        logic       j_zero;
    } dp_sts_t;

    function automatic logic [PC_W-1:0] popcount64(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] n;
        n = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            n = n + PC_W'(w[k]);
        end
        return n;
    endfunction

endpackage

// ----- design/bitvector_rank_select.sv -----
// ----------------------------------------------------------------------------
// bitvector_rank_select
// Succinct bit vector with a two-level rank directory, rank and select.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-word bit store to zero, one word per
// cycle, and holds busy high until the sweep is done; configuration writes are
// taken throughout. An item is taken when start is high and busy is low. Set
// reads and rewrites a word, get reads one, rank reads memory, takes a masked
// popcount and sums. Build walks the blocks one at a time. Select runs a binary
// search of up to 17 rank lookups, then steps back one rank lookup per position
// until it reaches the first match. The result beat shows on result for exactly
// one cycle with result_valid high; the receiver cannot stall it. Set, build and
// unused operation codes give no beat.
module bitvector_rank_select
    import brs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        result_valid,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] bit_count_reg;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    // single register at offset zero; writes ignore the address bits
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(bit_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_count_reg <= '0;
        else if (psel && penable && pwrite && pready)
            bit_count_reg <= pwdata[CNT_W-1:0];
    end

    brs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    brs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .bit_count    (bit_count_reg),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- design/brs_ctrl.sv -----
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer: clear pass, operation dispatch, build walk, rank and select loops.
// ----------------------------------------------------------------------------
module brs_ctrl
    import brs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    busy
);

    state_t  state_reg, state_next;
    rk_ret_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= RET_RANK;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_CLEAR:    if (sts.clr_done) state_next = S_IDLE;
            S_IDLE:     if (start) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_SET:    state_next = S_SET_RD;
                    OP_GET:    state_next = S_GET_RD;
                    OP_BUILD:  state_next = S_BLD_INIT;
                    OP_RANK:
                    begin
                        state_next = S_RK_RD;
                        ret_next   = RET_RANK;
                    end
                    OP_SELECT: state_next = S_SEL_INIT;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_SET_RD:   state_next = S_SET_WR;
            S_SET_WR:   state_next = S_IDLE;
            S_GET_RD:   state_next = S_GET_OUT;
            S_GET_OUT:  state_next = S_IDLE;
            S_BLD_INIT: state_next = S_BLD_CHK;
            S_BLD_CHK:  state_next = sts.bld_done ? S_IDLE : S_BLD_RD;
            S_BLD_RD:   state_next = S_BLD_PC;
            S_BLD_PC:   state_next = S_BLD_UPD;
            S_BLD_UPD:  state_next = S_BLD_CHK;
            S_RK_RD:    state_next = S_RK_PC;
            S_RK_PC:    state_next = S_RK_SUM;
            S_RK_SUM:
            begin
                case (ret_reg)
                    RET_SEARCH: state_next = S_SEL_CMP;
                    RET_BACK:   state_next = S_BACK_CMP;
                    default:    state_next = S_RK_OUT;
                endcase
            end
            S_RK_OUT:   state_next = S_IDLE;
            S_SEL_INIT: state_next = sts.want_zero ? S_IDLE : S_SEL_CHK;
            S_SEL_CHK:
            begin
                if (sts.left_gt_right)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RK_RD;
                    ret_next   = RET_SEARCH;
                end
            end
            S_SEL_CMP:  state_next = sts.rank_eq_want ? S_BACK_CHK : S_SEL_CHK;
            S_BACK_CHK:
            begin
                if (sts.j_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RK_RD;
                    ret_next   = RET_BACK;
                end
            end
            S_BACK_CMP: state_next = sts.rank_eq_want_m1 ? S_IDLE : S_BACK_CHK;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.emit = RES_NONE;
        busy     = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:    cmd.clr_wr = 1'b1;
            S_IDLE:     cmd.latch = start;
            S_DISPATCH: cmd.rank_init = (sts.op == OP_RANK);
            S_SET_WR:   cmd.set_wr = 1'b1;
            S_GET_OUT:  cmd.emit = RES_GET;
            S_BLD_INIT: cmd.bld_init = 1'b1;
            S_BLD_RD:   cmd.bld_addr = 1'b1;
            S_BLD_PC:   cmd.bld_pc = 1'b1;
            S_BLD_UPD:  cmd.bld_upd = 1'b1;
            S_RK_RD:    cmd.rk_addr = 1'b1;
            S_RK_PC:    cmd.rk_pc = 1'b1;
            S_RK_SUM:   cmd.rk_sum = 1'b1;
            S_RK_OUT:   cmd.emit = RES_RANK;
            S_SEL_INIT:
            begin
                if (sts.want_zero) cmd.emit = RES_ZERO;
                else               cmd.sel_init = 1'b1;
            end
            S_SEL_CHK:
            begin
                if (sts.left_gt_right) cmd.emit = RES_MISS;
                else                   cmd.sel_mid = 1'b1;
            end
            S_SEL_CMP:
            begin
                if (!sts.rank_eq_want)
                begin
                    cmd.sel_right = sts.rank_gt_want;
                    cmd.sel_left  = !sts.rank_gt_want;
                end
            end
            S_BACK_CHK:
            begin
                if (sts.j_zero) cmd.emit = RES_POS;
                else            cmd.back_pos = 1'b1;
            end
            S_BACK_CMP:
            begin
                if (sts.rank_eq_want_m1) cmd.emit = RES_POS;
                else                     cmd.back_dec = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/brs_dp.sv -----
// ----------------------------------------------------------------------------
// brs_dp
// Datapath: bit store, directory memories, popcount and rank sum, search regs.
// ----------------------------------------------------------------------------
module brs_dp
    import brs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            item,
    input  logic [CNT_W-1:0] bit_count,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    output logic             result_valid,
    output result_t          result
);

    logic [WORD_BITS-1:0] store_mem [STORE_WORDS];
    logic [CNT_W-1:0]     sb_mem    [SB_DEPTH];
    logic [BLK_W-1:0]     blk_mem   [BLK_DEPTH];

    logic [WA_W-1:0]      clr_reg;
    logic [2:0]           op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 val_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [CNT_W-1:0]     sbq_reg;
    logic [BLK_W-1:0]     blkq_reg;
    logic [POS_W-1:0]     rpos_reg;
    logic [PC_W-1:0]      pc_reg;
    logic [CNT_W-1:0]     part_reg;
    logic [CNT_W-1:0]     rank_reg;
    logic [BI_W-1:0]      bi_reg;
    logic [BI_W-1:0]      last_reg;
    logic [CNT_W-1:0]     sb_run_reg;
    logic [BLK_W-1:0]     blk_run_reg;
    logic [LR_W-1:0]      left_reg;
    logic [LR_W-1:0]      right_reg;
    logic [POS_W-1:0]     j_reg;
    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;

    logic [WA_W-1:0]      word_raddr;
    logic [BI_W-1:0]      bi_prev;
    logic [WORD_BITS-1:0] rank_mask;
    logic [WORD_BITS-1:0] set_word;
    logic [CNT_W-1:0]     used;
    logic [CNT_W-1:0]     sb_sum;
    logic [BLK_W-1:0]     blk_sum;
    logic [LR_W-1:0]      mid_sum;

    assign bi_prev    = bi_reg - BI_W'(1);
    assign word_raddr = cmd.bld_addr ? bi_prev[WA_W-1:0]
                      : (cmd.rk_addr ? rpos_reg[POS_W-1:6] : idx_reg[POS_W-1:6]);
    assign rank_mask  = {WORD_BITS{1'b1}} >> (6'd63 - rpos_reg[5:0]);
    assign used       = bit_count[CNT_W-1] ? CNT_W'(MAX_BITS) : bit_count;
    assign sb_sum     = sb_run_reg + CNT_W'(blk_run_reg) + CNT_W'(pc_reg);
    assign blk_sum    = blk_run_reg + BLK_W'(pc_reg);
    assign mid_sum    = left_reg + right_reg;

    always_comb
    begin
        set_word = word_reg;
        set_word[idx_reg[5:0]] = val_reg;
    end

    // result beat contents for the current emit command
    always_comb
    begin
        res_next = '0;
        case (cmd.emit)
            RES_GET:  res_next.bit_out = !idx_reg[IDX_W-1] && word_reg[idx_reg[5:0]];
            RES_RANK: res_next.count_out = rank_reg;
            RES_POS:  res_next.position = j_reg;
            RES_MISS: res_next.not_found = 1'b1;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            store_mem[clr_reg] <= '0;
        else if (cmd.set_wr && !idx_reg[IDX_W-1])
            store_mem[idx_reg[POS_W-1:6]] <= set_word;
        word_reg <= store_mem[word_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bld_init)
            sb_mem[0] <= '0;
        else if (cmd.bld_upd && bi_reg[2:0] == 3'd0 && !bi_reg[BI_W-1])
            sb_mem[bi_reg[BI_W-2:3]] <= sb_sum;
        sbq_reg <= sb_mem[rpos_reg[POS_W-1:9]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bld_init)
            blk_mem[0] <= '0;
        else if (cmd.bld_upd && !bi_reg[BI_W-1])
            blk_mem[bi_reg[WA_W-1:0]] <= (bi_reg[2:0] == 3'd0) ? '0 : blk_sum;
        blkq_reg <= blk_mem[rpos_reg[POS_W-1:6]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr) clr_reg <= clr_reg + WA_W'(1);
            res_valid_reg <= (cmd.emit != RES_NONE);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= item.operation;
            idx_reg <= item.index;
            val_reg <= item.bit_value;
        end
        if (cmd.rank_init)
            rpos_reg <= idx_reg[IDX_W-1] ? {POS_W{1'b1}} : idx_reg[POS_W-1:0];
        if (cmd.rk_pc)
        begin
            pc_reg   <= popcount64(word_reg & rank_mask);
            part_reg <= sbq_reg + CNT_W'(blkq_reg);
        end
        if (cmd.bld_pc)
            pc_reg <= popcount64(word_reg);
        if (cmd.rk_sum)
            rank_reg <= part_reg + CNT_W'(pc_reg);
        if (cmd.bld_init)
        begin
            bi_reg      <= BI_W'(1);
            last_reg    <= used[CNT_W-1:6];
            sb_run_reg  <= '0;
            blk_run_reg <= '0;
        end
        if (cmd.bld_upd)
        begin
            bi_reg <= bi_reg + BI_W'(1);
            if (bi_reg[2:0] == 3'd0)
            begin
                sb_run_reg  <= sb_sum;
                blk_run_reg <= '0;
            end
            else
            begin
                blk_run_reg <= blk_sum;
            end
        end
        if (cmd.sel_init)
        begin
            left_reg  <= '0;
            right_reg <= LR_W'(used) - LR_W'(1);
        end
        if (cmd.sel_mid)
        begin
            j_reg    <= mid_sum[POS_W:1];
            rpos_reg <= mid_sum[POS_W:1];
        end
        if (cmd.sel_left)  left_reg  <= LR_W'(j_reg) + LR_W'(1);
        if (cmd.sel_right) right_reg <= LR_W'(j_reg) - LR_W'(1);
        if (cmd.back_pos)  rpos_reg  <= j_reg - POS_W'(1);
        if (cmd.back_dec)  j_reg     <= j_reg - POS_W'(1);
        if (cmd.emit != RES_NONE)
            res_reg <= res_next;
    end

    always_comb
    begin
        sts.op              = op_reg;
        sts.clr_done        = (clr_reg == {WA_W{1'b1}});
        sts.bld_done        = (bi_reg > last_reg);
        sts.want_zero       = (idx_reg == '0);
        sts.left_gt_right   = ($signed(left_reg) > $signed(right_reg));
        sts.rank_eq_want    = (rank_reg == idx_reg);
        sts.rank_gt_want    = (rank_reg > idx_reg);
        sts.rank_eq_want_m1 = (rank_reg == idx_reg - CNT_W'(1));
        sts.j_zero          = (j_reg == '0);
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- design/brs_checker.sv -----
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks on the rank/select block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitvector_rank_select_assert.svh"

module brs_checker
    import brs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    `BRS_ASSERT_NOW(a_beat_when_idle, result_valid, !busy, "result beat while busy")
    `BRS_ASSERT_NEXT(a_single_beat, result_valid, !result_valid, "two result beats in a row")
    `BRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `BRS_ASSERT_NOW(a_miss_clean, result_valid && result.not_found, result.position == '0 && result.count_out == '0 && !result.bit_out, "miss beat carries data")

endmodule

bind bitvector_rank_select brs_checker u_brs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ----- verif/tb_bitvector_rank_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitvector_rank_select
// Self-checking bench for the rank/select bit vector block. A tracker class
// keeps its own bit store and rank directory, predicts each get, rank and
// select answer as the op beat is taken, and compares every result beat in
// order. Phases step bit_count through small, odd and extreme sizes with
// different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_bitvector_rank_select;
    import brs_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int SHOWN_MAX   = 10;

    // ------------------------------------------------------------------------
    // Tracker: shadow bit store, shadow directory and answers still due
    // ------------------------------------------------------------------------
    class rank_select_tracker;
        bit          store[MAX_BITS];
        int unsigned sb_cnt[SB_DEPTH];
        int unsigned blk_cnt[BLK_DEPTH];
        bit          sb_seen[SB_DEPTH];
        bit          blk_seen[BLK_DEPTH];
        int unsigned bit_count;
        result_t     answers_due[$];
        int          errors;
        int          shown;

        function int unsigned used();
            return (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
        endfunction

        function int unsigned bit_at(longint unsigned p);
            return (p >= MAX_BITS) ? 0 : store[p];
        endfunction

        function int unsigned ones_in(longint unsigned beg, int unsigned len);
            int unsigned n;
            n = 0;
            for (int unsigned t = 0; t < len; t++)
                n += bit_at(beg + t);
            return n;
        endfunction

        function int unsigned sb_at(longint unsigned i);
            return (i < SB_DEPTH) ? sb_cnt[i] : 0;
        endfunction

        function int unsigned blk_at(longint unsigned i);
            return (i < BLK_DEPTH) ? blk_cnt[i] : 0;
        endfunction

        // Rebuild the directory from the store as it stands now.
        function void rebuild();
            int unsigned last;
            int unsigned ones;
            int unsigned s;
            last = used() / BLOCK_BITS;
            sb_cnt[0] = 0;
            sb_seen[0] = 1;
            blk_cnt[0] = 0;
            blk_seen[0] = 1;
            for (int unsigned i = 1; i <= last; i++)
            begin
                ones = ones_in(longint'(i - 1) * BLOCK_BITS, BLOCK_BITS);
                if (i % BLK_PER_SB == 0)
                begin
                    s = i / BLK_PER_SB;
                    if (s < SB_DEPTH)
                    begin
                        sb_cnt[s] = sb_at(s - 1) + blk_at(i - 1) + ones;
                        sb_seen[s] = 1;
                    end
                    if (i < BLK_DEPTH)
                    begin
                        blk_cnt[i] = 0;
                        blk_seen[i] = 1;
                    end
                end
                else if (i < BLK_DEPTH)
                begin
                    blk_cnt[i] = blk_at(i - 1) + ones;
                    blk_seen[i] = 1;
                end
            end
        endfunction

        function int unsigned rank_of(longint unsigned p);
            longint unsigned b;
            if (p >= MAX_BITS)
                p = MAX_BITS - 1;
            b = p / BLOCK_BITS;
            return sb_at(p / SB_BITS) + blk_at(b) + ones_in(b * BLOCK_BITS, (p % BLOCK_BITS) + 1);
        endfunction

        // Binary search by rank, then walk back to the first match.
        function void find_one(input int unsigned want, output int unsigned pos,
                               output bit miss);
            longint lo;
            longint hi;
            longint j;
            int unsigned r;
            bit hit;
            lo = 0;
            hi = longint'(used()) - 1;
            j = 0;
            hit = 0;
            pos = 0;
            miss = 0;
            if (want == 0)
                return;
            while (lo <= hi && !hit)
            begin
                j = (lo + hi) / 2;
                r = rank_of(j);
                if (r == want)
                    hit = 1;
                else if (r > want)
                    hi = j - 1;
                else
                    lo = j + 1;
            end
            if (!hit)
            begin
                miss = 1;
                return;
            end
            while (j > 0 && rank_of(j - 1) != want - 1)
                j--;
            pos = j;
        endfunction

        // Directory entries read by a rank at p have been built at least once.
        function bit rank_safe(int unsigned p);
            if (p >= MAX_BITS)
                p = MAX_BITS - 1;
            return blk_seen[p / BLOCK_BITS] && sb_seen[p / SB_BITS];
        endfunction

        function bit select_safe(int unsigned want);
            if (want == 0 || used() == 0)
                return 1;
            return rank_safe(used() - 1);
        endfunction

        function int unsigned ones_in_use();
            return ones_in(0, used());
        endfunction

        // Apply an accepted op beat and queue the answer it owes.
        function void take_op(item_t it);
            result_t ans;
            int unsigned p;
            bit m;
            ans = '0;
            case (it.operation)
                OP_SET:
                begin
                    if (it.index < MAX_BITS)
                        store[it.index] = it.bit_value;
                end
                OP_BUILD:
                    rebuild();
                OP_GET:
                begin
                    ans.bit_out = bit_at(it.index);
                    answers_due.push_back(ans);
                end
                OP_RANK:
                begin
                    ans.count_out = CNT_W'(rank_of(it.index));
                    answers_due.push_back(ans);
                end
                OP_SELECT:
                begin
                    find_one(it.index, p, m);
                    ans.position = POS_W'(p);
                    ans.not_found = m;
                    answers_due.push_back(ans);
                end
                default: ;
            endcase
        endfunction

        function void match_answer(result_t got);
            result_t want;
            if (answers_due.size() == 0)
            begin
                errors++;
                if (shown < SHOWN_MAX)
                begin
                    shown++;
                    $display("unexpected result beat: %p", got);
                end
                return;
            end
            want = answers_due.pop_front();
            if (got.bit_out !== want.bit_out || got.count_out !== want.count_out ||
                got.position !== want.position || got.not_found !== want.not_found)
            begin
                errors++;
                if (shown < SHOWN_MAX)
                begin
                    shown++;
                    $display("mismatch: expected bit %0d count %0d pos %0d miss %0d, ",
                             want.bit_out, want.count_out, want.position, want.not_found,
                             "got bit %0d count %0d pos %0d miss %0d",
                             got.bit_out, got.count_out, got.position, got.not_found);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       item = '0;
    logic        busy;
    logic        result_valid;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rank_select_tracker vec = new();
    int unsigned        cycles = 0;
    int                 gap_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bitvector_rank_select uut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .result_valid(result_valid), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Compare every result beat; values sampled here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            vec.match_answer(result);
    end

    // Watchdog: drop out if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Write bit_count over the APB port: setup, then access.
    task automatic write_bit_count(int unsigned v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vec.bit_count = v & 32'h1FFFF;
    endtask

    // Hold an op beat until taken, then maybe idle the sender for a while.
    task automatic issue(logic [2:0] op, int unsigned idx, bit v);
        item_t it;
        it.operation = op;
        it.index = idx[IDX_W-1:0];
        it.bit_value = v;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        vec.take_op(it);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drain all owed answers and let the block settle before touching config.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (vec.answers_due.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Random ops: sets, gets, builds, ranks and selects mixed, indices mostly near the used range.
    task automatic random_phase(int unsigned n);
        int unsigned pick;
        int unsigned idx;
        int unsigned hi;
        int unsigned ones;
        logic [2:0]  op;
        bit          big;
        big = vec.used() > 4096;
        for (int unsigned k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            hi = vec.used() + 63;
            if (hi > 131071)
                hi = 131071;
            idx = ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(hi);
            if (pick < 38)
                op = OP_SET;
            else if (pick < 52)
                op = OP_GET;
            else if (pick < (big ? 54 : 60))
                op = OP_BUILD;
            else if (pick < 78)
                op = OP_RANK;
            else if (pick < 96)
                op = OP_SELECT;
            else
                op = 3'($urandom_range(5, 7));
            if (op == OP_SELECT)
            begin
                ones = vec.ones_in_use();
                // Keep long walk-backs out of the big vectors.
                if (big)
                    idx = ($urandom_range(1) == 0) ? 0 : ones + $urandom_range(1, 3);
                else if ($urandom_range(19) != 0)
                    idx = $urandom_range(ones + 2);
                if (!vec.select_safe(idx))
                    op = OP_GET;
            end
            if (op == OP_RANK && !vec.rank_safe(idx))
                op = OP_GET;
            issue(op, idx, $urandom_range(1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned counts[7] = '{0, 300, 131071, 64, 1000, 517, 131};
        int unsigned lens[7]   = '{60, 200, 40, 200, 250, 250, 200};
        int          pcts[4]   = '{0, 71, 0, 34};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full-size vector, storage edges, stale directory, misses.
        write_bit_count(MAX_BITS);
        issue(OP_BUILD, 0, 0);
        issue(OP_SELECT, 5, 0);
        issue(OP_SELECT, 0, 0);
        issue(OP_RANK, 131071, 0);
        issue(OP_SET, 0, 1);
        issue(OP_SET, 1, 1);
        issue(OP_SET, 65535, 1);
        issue(OP_SET, 65536, 1);
        issue(OP_SET, 131071, 1);
        issue(OP_GET, 0, 0);
        issue(OP_GET, 65535, 0);
        issue(OP_GET, 65536, 0);
        issue(OP_GET, 131071, 0);
        issue(OP_RANK, 65535, 0);
        issue(OP_BUILD, 0, 0);
        issue(OP_RANK, 0, 0);
        issue(OP_RANK, 131071, 0);
        issue(OP_SELECT, 1, 0);
        issue(OP_SELECT, 3, 0);
        issue(OP_SELECT, 4, 0);
        issue(3'd5, 7, 1);
        issue(3'd6, 0, 0);
        issue(3'd7, 131071, 1);
        issue(OP_SET, 1, 0);
        issue(OP_GET, 1, 0);
        settle();

        for (int ph = 0; ph < 7; ph++)
        begin
            gap_pct = pcts[ph % 4];
            write_bit_count(counts[ph]);
            random_phase(lens[ph]);
            settle();
        end

        if (vec.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- bitvector_rank_select.f -----
+incdir+design
design/brs_pkg.sv
design/brs_ctrl.sv
design/brs_dp.sv
design/bitvector_rank_select.sv
design/brs_checker.sv
verif/tb_bitvector_rank_select.sv
